/* rtl/two_level_watchdog_supervisor_macros.svh */
// Assertion macros shared by the watchdog supervisor RTL.
`ifndef TWO_LEVEL_WATCHDOG_SUPERVISOR_MACROS_SVH
`define TWO_LEVEL_WATCHDOG_SUPERVISOR_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define TLWS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define TLWS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/tlws_pkg.sv */
// Types and constants of the two-level watchdog supervisor.
`timescale 1ns / 1ps

package tlws_pkg;

  localparam int unsigned HwCountW  = 9;
  localparam int unsigned HwSecsW   = 8;
  localparam int unsigned SwFieldW  = 16;
  localparam logic [HwSecsW-1:0] DefaultSecs = 8'd60;

  typedef enum logic {
    KIND_TICK = 1'b0,
    KIND_CTRL = 1'b1
  } item_kind_e;

  typedef struct packed {
    item_kind_e          kind;
    logic                force_reset;
    logic                set_hw_timeout;
    logic                set_sw_timeout;
    logic                pet_supervisor;
    logic                petting_on;
    logic                petting_off;
    logic [HwSecsW-1:0]  hw_seconds;
    logic [SwFieldW-1:0] sw_seconds;
  } in_item_t;

  typedef struct packed {
    logic                reset_out;
    logic                hw_running;
    logic [HwCountW-1:0] hw_remaining;
    logic [SwFieldW-1:0] sw_remaining;
  } out_item_t;

endpackage

/* rtl/tlws_chan_if.sv */
// Valid/ready channel carrying one payload beat.
`timescale 1ns / 1ps

interface tlws_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

/* rtl/two_level_watchdog_supervisor.sv */
// Pipeline: input reg, then result reg; a result beat that is not taken stalls the input reg.
// Throughput: one item per cycle while the output is ready; a waiting result lets one more
// beat into the input register, then holds the input until the result beat leaves.
// The single state update lies between the input register and the result register.
// Reset: rst_ni clears all control state; timeouts return to 60 s, counts to zero.
`timescale 1ns / 1ps
`include "two_level_watchdog_supervisor_macros.svh"

module two_level_watchdog_supervisor
  import tlws_pkg::*;
#(
  parameter int unsigned MAX_HW_SECONDS = 128,
  parameter int unsigned SW_COUNT_BITS  = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  tlws_chan_if.sink    in_i,
  tlws_chan_if.source  out_o
);

  localparam int unsigned SwW = SW_COUNT_BITS;
  localparam logic [HwSecsW-1:0]  HwMaxSecs  = HwSecsW'(MAX_HW_SECONDS);
  localparam logic [HwCountW-1:0] HwMaxCount = HwCountW'(2 * MAX_HW_SECONDS);

  // Input stage
  logic     in_valid_q;
  in_item_t in_item_q;
  logic     advance;

  // Result stage
  logic      out_valid_q;
  out_item_t out_item_q;

  // Watchdog state
  logic [HwSecsW-1:0]  hw_timeout_q, hw_timeout_d;
  logic [SwW-1:0]      sw_timeout_q, sw_timeout_d;
  logic [SwW-1:0]      sw_count_q, sw_count_d;
  logic [HwCountW-1:0] hw_count_q, hw_count_d;
  logic                hw_enabled_q, hw_enabled_d;
  logic                pet_enabled_q, pet_enabled_d;
  logic                timer_active_q, timer_active_d;
  logic                tick_phase_q, tick_phase_d;
  logic                reset_latched_q, reset_latched_d;

  assign advance    = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_item_q <= in_i.payload;
    end
  end

  // Apply one item to the state
  always_comb begin
    logic                fire;
    logic [HwSecsW-1:0]  clamped;

    hw_timeout_d    = hw_timeout_q;
    sw_timeout_d    = sw_timeout_q;
    sw_count_d      = sw_count_q;
    hw_count_d      = hw_count_q;
    hw_enabled_d    = hw_enabled_q;
    pet_enabled_d   = pet_enabled_q;
    timer_active_d  = timer_active_q;
    tick_phase_d    = tick_phase_q;
    reset_latched_d = reset_latched_q;
    fire            = 1'b0;
    clamped         = in_item_q.hw_seconds;

    if (in_item_q.hw_seconds == '0) begin
      clamped = HwSecsW'(1);
    end else if (in_item_q.hw_seconds > HwMaxSecs) begin
      clamped = HwMaxSecs;
    end

    if (!reset_latched_q) begin
      case (in_item_q.kind)
        KIND_TICK: begin
          if (hw_enabled_q) begin
            if (hw_count_q != '0) begin
              hw_count_d = hw_count_q - HwCountW'(1);
            end
            if (hw_count_q <= HwCountW'(1)) begin
              reset_latched_d = 1'b1;
            end
          end
          if (!reset_latched_d && timer_active_q) begin
            tick_phase_d = !tick_phase_q;
            fire         = tick_phase_q;
          end
        end
        KIND_CTRL: begin
          if (in_item_q.force_reset) begin
            reset_latched_d = 1'b1;
          end else begin
            if (in_item_q.set_hw_timeout) begin
              hw_timeout_d = clamped;
            end
            if (in_item_q.set_sw_timeout) begin
              sw_timeout_d = SwW'(in_item_q.sw_seconds);
              sw_count_d   = SwW'(in_item_q.sw_seconds);
            end else if (in_item_q.pet_supervisor) begin
              sw_count_d = sw_timeout_q;
            end
            if (in_item_q.petting_on) begin
              pet_enabled_d = 1'b1;
              if (!timer_active_q) begin
                timer_active_d = 1'b1;
                tick_phase_d   = 1'b0;
                fire           = 1'b1;
              end
            end
            if (in_item_q.petting_off) begin
              pet_enabled_d = 1'b0;
            end
            // Start, or reload on a changed timeout
            if (!hw_enabled_q || hw_timeout_d != hw_timeout_q) begin
              hw_enabled_d = 1'b1;
              hw_count_d   = {hw_timeout_d, 1'b0};
            end
          end
        end
        default: begin
        end
      endcase

      // Supervisor pet: reload the watchdog and spend one pet
      if (fire && pet_enabled_d && sw_count_d != '0) begin
        if (hw_enabled_d) begin
          hw_count_d = {hw_timeout_d, 1'b0};
        end
        sw_count_d = sw_count_d - SwW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hw_timeout_q    <= DefaultSecs;
      sw_timeout_q    <= SwW'(DefaultSecs);
      sw_count_q      <= '0;
      hw_count_q      <= '0;
      hw_enabled_q    <= 1'b0;
      pet_enabled_q   <= 1'b0;
      timer_active_q  <= 1'b0;
      tick_phase_q    <= 1'b0;
      reset_latched_q <= 1'b0;
      out_valid_q     <= 1'b0;
    end else begin
      if (advance) begin
        hw_timeout_q    <= hw_timeout_d;
        sw_timeout_q    <= sw_timeout_d;
        sw_count_q      <= sw_count_d;
        hw_count_q      <= hw_count_d;
        hw_enabled_q    <= hw_enabled_d;
        pet_enabled_q   <= pet_enabled_d;
        timer_active_q  <= timer_active_d;
        tick_phase_q    <= tick_phase_d;
        reset_latched_q <= reset_latched_d;
        out_valid_q     <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_item_q.reset_out    <= reset_latched_d;
      out_item_q.hw_running   <= hw_enabled_d;
      out_item_q.hw_remaining <= hw_count_d;
      out_item_q.sw_remaining <= SwFieldW'(sw_count_d);
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_item_q;

  `TLWS_ASSERT_NEXT(a_reset_sticks, reset_latched_q, reset_latched_q,
                    "latched reset was released")
  `TLWS_ASSERT_NEXT(a_frozen_counts, reset_latched_q,
                    $stable(hw_count_q) && $stable(sw_count_q),
                    "counts moved after reset latched")
  `TLWS_ASSERT_SAME(a_idle_count_zero, !hw_enabled_q, hw_count_q == '0,
                    "watchdog count nonzero before start")
  `TLWS_ASSERT_SAME(a_count_bound, 1'b1, hw_count_q <= HwMaxCount,
                    "watchdog count above twice the maximum timeout")
  `TLWS_ASSERT_SAME(a_timeout_range, 1'b1,
                    hw_timeout_q != '0 && hw_timeout_q <= HwMaxSecs,
                    "hardware timeout out of range")

endmodule
